>>> sv/assert_macros.svh
// Assertion macros used by the RTL of this block (included by okv_ctrl).
// The clocked forms sample on clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

>>> sv/okv_pkg.sv
// ----------------------------------------------------------------------------
// okv_pkg: shared types and constants of the ordered key/value table
// Sizes, operation and status codes, the stored entry type and the string
// canonicalization function.
// ----------------------------------------------------------------------------
package okv_pkg;

	localparam int DEPTH      = 64;
	localparam int NAME_BYTES = 8;
	localparam int STR_W      = 64;
	localparam int COUNT_W    = 7;
	localparam int STEP_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NEXT_IDX   = (DEPTH > 1) ? 1 : 0;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_DUMP   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_DUMPED    = 3'd5
	} status_t;

	typedef struct packed {
		logic [STR_W-1:0] name;
		logic [STR_W-1:0] definition;
	} entry_t;

	// Keeps the low NAME_BYTES bytes and clears everything after the first zero byte.
	function automatic logic [STR_W-1:0] canon(input logic [STR_W-1:0] v);
		logic [STR_W-1:0] r;
		logic             alive;
		r     = '0;
		alive = 1'b1;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (v[8*b +: 8] == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				r[8*b +: 8] = v[8*b +: 8];
			end
		end
		return r;
	endfunction

endpackage

>>> sv/okv_req_if.sv
// ----------------------------------------------------------------------------
// okv_req_if: request channel of the ordered key/value table
// One beat carries an operation code, a name and a definition.
// ----------------------------------------------------------------------------
interface okv_req_if import okv_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       operation;
	logic [STR_W-1:0] key_name;
	logic [STR_W-1:0] key_definition;

	modport source (output valid, output operation, output key_name, output key_definition,
		input ready);
	modport sink (input valid, input operation, input key_name, input key_definition,
		output ready);
endinterface

>>> sv/okv_rsp_if.sv
// ----------------------------------------------------------------------------
// okv_rsp_if: result channel of the ordered key/value table
// One beat carries a status, an entry, the last flag and the entry count.
// ----------------------------------------------------------------------------
interface okv_rsp_if import okv_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [STR_W-1:0]   entry_name;
	logic [STR_W-1:0]   entry_definition;
	logic               last;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output status, output entry_name, output entry_definition,
		output last, output count, input ready);
	modport sink (input valid, input status, input entry_name, input entry_definition,
		input last, input count, output ready);
endinterface

>>> sv/okv_cell.sv
// ----------------------------------------------------------------------------
// okv_cell: one storage cell of the rotating entry chain
// Holds one name/definition pair and loads its neighbor's pair on a shift.
// ----------------------------------------------------------------------------
module okv_cell import okv_pkg::*; (
	input  logic   clk,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

>>> sv/okv_ctrl.sv
// ----------------------------------------------------------------------------
// okv_ctrl: sequencer of the ordered key/value table
// Rotates the cell chain once around per operation, inspects the head cell,
// rewrites the tail cell and produces the result beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module okv_ctrl import okv_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	okv_req_if.sink   req,
	okv_rsp_if.source rsp,
	input  entry_t head,
	input  entry_t next,
	output logic   shift,
	output entry_t tail
);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [STR_W-1:0]   key_name_q;
	logic [STR_W-1:0]   key_def_q;
	logic [STEP_W-1:0]  step_q;
	logic               found_q;
	logic               added_q;
	logic [COUNT_W-1:0] count_q;

	logic               rsp_valid_q;
	status_t            rsp_status_q;
	logic [STR_W-1:0]   rsp_name_q;
	logic [STR_W-1:0]   rsp_def_q;
	logic               rsp_last_q;
	logic [COUNT_W-1:0] rsp_count_q;

	logic               accept;
	logic               out_free;
	logic               step_go;
	logic               final_step;
	logic [COUNT_W-1:0] step_ext;
	logic               in_range;
	logic               match;
	logic               append_here;
	logic               found_now;
	logic               added_now;
	logic               emit;
	status_t            emit_status;
	logic [STR_W-1:0]   emit_name;
	logic [STR_W-1:0]   emit_def;
	logic               emit_last;
	logic [COUNT_W-1:0] emit_count;
	logic [COUNT_W-1:0] count_next;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign step_go   = (state_q == S_RUN) && out_free;
	assign final_step = step_go && (step_q == STEP_W'(DEPTH - 1));
	assign shift     = step_go;

	assign step_ext    = COUNT_W'(step_q);
	assign in_range    = step_ext < count_q;
	assign match       = in_range && (head.name == key_name_q) &&
		((op_q == OP_PUT) || (op_q == OP_REMOVE));
	// The first free slot comes around right after the last stored entry.
	assign append_here = (op_q == OP_PUT) && !found_q && (step_ext == count_q);
	assign found_now   = found_q || match;
	assign added_now   = added_q || append_here;

	always_comb begin
		tail = head;
		case (op_q)
			OP_PUT: begin
				if (match && !found_q) begin
					tail.definition = key_def_q;
				end else if (append_here) begin
					tail.name       = key_name_q;
					tail.definition = key_def_q;
				end
			end
			OP_REMOVE: begin
				// From the removed entry on, each slot takes its successor.
				if (found_now) begin
					tail = next;
				end
			end
			default: begin
				tail = head;
			end
		endcase
	end

	always_comb begin
		count_next = count_q;
		if (op_q == OP_PUT && added_now) begin
			count_next = count_q + COUNT_W'(1);
		end else if (op_q == OP_REMOVE && found_now) begin
			count_next = count_q - COUNT_W'(1);
		end
	end

	always_comb begin
		emit        = 1'b0;
		emit_status = ST_DUMPED;
		emit_name   = '0;
		emit_def    = '0;
		emit_last   = 1'b1;
		emit_count  = count_next;
		case (op_q)
			OP_PUT: begin
				emit        = final_step;
				emit_status = found_now ? ST_UPDATED : (added_now ? ST_ADDED : ST_FULL);
			end
			OP_REMOVE: begin
				emit        = final_step;
				emit_status = found_now ? ST_REMOVED : ST_NOT_FOUND;
			end
			OP_DUMP: begin
				emit        = step_go && in_range;
				emit_status = ST_DUMPED;
				emit_name   = head.name;
				emit_def    = head.definition;
				emit_last   = (step_ext + COUNT_W'(1)) == count_q;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_name_q <= canon(req.key_name);
			key_def_q  <= canon(req.key_definition);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_NONE;
			step_q       <= '0;
			found_q      <= 1'b0;
			added_q      <= 1'b0;
			count_q      <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_DUMPED;
			rsp_name_q   <= '0;
			rsp_def_q    <= '0;
			rsp_last_q   <= 1'b0;
			rsp_count_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= op_t'(req.operation);
						step_q  <= '0;
						found_q <= 1'b0;
						added_q <= 1'b0;
						if (op_t'(req.operation) != OP_NONE) begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (step_go) begin
						step_q  <= step_q + STEP_W'(1);
						found_q <= found_now;
						added_q <= added_now;
						if (final_step) begin
							count_q <= count_next;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_free) begin
				rsp_valid_q  <= emit;
				rsp_status_q <= emit_status;
				rsp_name_q   <= emit_name;
				rsp_def_q    <= emit_def;
				rsp_last_q   <= emit_last;
				rsp_count_q  <= emit_count;
			end
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.entry_name       = rsp_name_q;
	assign rsp.entry_definition = rsp_def_q;
	assign rsp.last             = rsp_last_q;
	assign rsp.count            = rsp_count_q;

	`ASSERT_CLK(a_count_in_range, count_q <= COUNT_W'(DEPTH), "entry count exceeds depth")
	`ASSERT_IMPLY(a_count_at_end, !$stable(count_q), $past(final_step), "count moved mid-pass")
	`ASSERT_IMPLY(a_remove_nonempty, final_step && op_q == OP_REMOVE && found_now,
		count_q != '0, "remove matched in an empty table")
	`ASSERT_IMPLY(a_no_accept_busy, accept, state_q == S_IDLE && !shift, "beat taken mid-pass")

endmodule

>>> sv/ordered_key_value_table.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table: insertion-ordered name/definition table
// A ring of DEPTH storage cells rotated by a small sequencer.
// ----------------------------------------------------------------------------
// Every put, remove or dump is accepted and then the cell ring turns once
// around, one position per cycle while no result beat waits for the sink,
// so that each stored entry passes the head cell in order. Operation code 3
// is accepted and does nothing. A new request is taken only after the pass
// of the previous one, while its last result may still wait at the output.
// Put and remove give one status beat; a dump gives one beat per entry with
// last on the final one, and none for an empty table.

module ordered_key_value_table import okv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	okv_req_if.sink   req,
	okv_rsp_if.source rsp
);

	entry_t cell_d [DEPTH];
	entry_t cell_q [DEPTH];
	entry_t tail;
	logic   shift;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == DEPTH - 1) begin : g_tail
			assign cell_d[g] = tail;
		end else begin : g_link
			assign cell_d[g] = cell_q[g + 1];
		end
		okv_cell u_cell (
			.clk   (clk),
			.shift (shift),
			.d     (cell_d[g]),
			.q     (cell_q[g])
		);
	end

	okv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.head   (cell_q[0]),
		.next   (cell_q[NEXT_IDX]),
		.shift  (shift),
		.tail   (tail)
	);

endmodule
